// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the body canonicalizer, used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DBC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define DBC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/dbc_pkg.sv =====
// Types and constants shared by the body canonicalizer modules.
package dbc_pkg;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RELAXED_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HOLD_CR,
		ST_HOLD_LF,
		ST_SPACE,
		ST_BYTE,
		ST_END_CR,
		ST_END_LF
	} state_t;

	typedef struct packed {
		logic relaxed;
		logic limit_en;
	} mode_t;

	typedef struct packed {
		logic load;
		logic dec;
	} budget_ctl_t;

	typedef struct packed {
		logic zero;
		logic one;
		logic le2;
	} budget_sts_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic       body_done;
		logic       length_met;
		logic       line_overflow;
	} result_t;

endpackage

// ===== sv/dbc_budget.sv =====
// Remaining-length counter: loaded at body start, decremented per emitted byte.
module dbc_budget (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          length_limit,
	input  dbc_pkg::budget_ctl_t ctl,
	output dbc_pkg::budget_sts_t sts
);
	import dbc_pkg::*;

	logic [31:0] bytes_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 32'd0;
		end else if (ctl.load) begin
			bytes_left_q <= length_limit;
		end else if (ctl.dec) begin
			bytes_left_q <= bytes_left_q - 32'd1;
		end
	end

	always_comb begin
		sts.zero = (bytes_left_q == 32'd0);
		sts.one  = (bytes_left_q == 32'd1);
		sts.le2  = (bytes_left_q < 32'd3);
	end

endmodule

// ===== sv/dbc_seq.sv =====
// Sequencer: classifies input bytes and emits canonical results one per cycle while out_free is high.
module dbc_seq #(
	parameter int unsigned MAX_HELD_LINES = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           body_byte,
	input  logic                 end_of_body,
	input  dbc_pkg::mode_t       mode,
	input  dbc_pkg::budget_sts_t bsts,
	output dbc_pkg::budget_ctl_t bctl,
	input  logic                 out_free,
	output logic                 push,
	output dbc_pkg::result_t     res
);
	import dbc_pkg::*;

	localparam int unsigned HeldW = $clog2(MAX_HELD_LINES + 1);

	state_t state_q, state_d;

	logic [HeldW-1:0] held_q;
	logic             pending_q;
	logic             nonempty_q;
	logic             overflow_q;
	logic             started_q;
	logic             met_q;
	logic [7:0]       byte_q;

	logic accept, is_cr, is_lf, is_ws, is_content;
	logic allow, budget_last, emit_crlf;
	logic clr_content, clr_body, dec_held, set_met, met_val;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign is_cr      = (body_byte == CHAR_CR);
	assign is_lf      = (body_byte == CHAR_LF);
	assign is_ws      = mode.relaxed && ((body_byte == CHAR_SPACE) || (body_byte == CHAR_TAB));
	assign is_content = !end_of_body && !is_cr && !is_lf && !is_ws;

	// A byte may leave only while the budget is open; the one that closes it ends the run.
	assign allow       = !mode.limit_en || !bsts.zero;
	assign budget_last = mode.limit_en && bsts.one;
	assign emit_crlf   = nonempty_q || !mode.relaxed;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (end_of_body) begin
						state_d = ST_END_CR;
					end else if (is_content) begin
						if (held_q != '0) begin
							state_d = ST_HOLD_CR;
						end else if (pending_q) begin
							state_d = ST_SPACE;
						end else begin
							state_d = ST_BYTE;
						end
					end
				end
			end
			ST_HOLD_CR: begin
				if (out_free) begin
					state_d = (!allow || budget_last) ? ST_IDLE : ST_HOLD_LF;
				end
			end
			ST_HOLD_LF: begin
				if (out_free) begin
					if (!allow || budget_last) begin
						state_d = ST_IDLE;
					end else if (held_q == HeldW'(1)) begin
						state_d = pending_q ? ST_SPACE : ST_BYTE;
					end else begin
						state_d = ST_HOLD_CR;
					end
				end
			end
			ST_SPACE: begin
				if (out_free) begin
					state_d = (!allow || budget_last) ? ST_IDLE : ST_BYTE;
				end
			end
			ST_BYTE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_END_CR: begin
				if (out_free) begin
					state_d = (emit_crlf && allow && !budget_last) ? ST_END_LF : ST_IDLE;
				end
			end
			ST_END_LF: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and register update strobes.
	always_comb begin
		push              = 1'b0;
		res.out_byte      = 8'd0;
		res.byte_valid    = 1'b1;
		res.last          = budget_last;
		res.body_done     = 1'b0;
		res.length_met    = 1'b0;
		res.line_overflow = overflow_q;
		clr_content       = 1'b0;
		clr_body          = 1'b0;
		dec_held          = 1'b0;
		set_met           = 1'b0;
		met_val           = 1'b0;
		in_ready          = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
			end
			ST_HOLD_CR: begin
				res.out_byte = CHAR_CR;
				if (out_free) begin
					push        = allow;
					clr_content = !allow || budget_last;
				end
			end
			ST_HOLD_LF: begin
				res.out_byte = CHAR_LF;
				if (out_free) begin
					push        = allow;
					clr_content = !allow || budget_last;
					dec_held    = allow && !budget_last;
				end
			end
			ST_SPACE: begin
				res.out_byte = CHAR_SPACE;
				if (out_free) begin
					push        = allow;
					clr_content = 1'b1;
				end
			end
			ST_BYTE: begin
				res.out_byte = byte_q;
				res.last     = 1'b1;
				if (out_free) begin
					push        = allow;
					clr_content = 1'b1;
				end
			end
			ST_END_CR: begin
				res.body_done = 1'b1;
				if (emit_crlf && allow) begin
					res.out_byte   = CHAR_CR;
					res.length_met = !mode.limit_en || bsts.le2;
				end else begin
					// Nothing left to send: a lone status result closes the body.
					res.byte_valid = 1'b0;
					res.last       = 1'b1;
					res.length_met = !mode.limit_en || bsts.zero;
				end
				if (out_free) begin
					push     = 1'b1;
					set_met  = 1'b1;
					met_val  = res.length_met;
					clr_body = !(emit_crlf && allow && !budget_last);
				end
			end
			ST_END_LF: begin
				res.out_byte   = CHAR_LF;
				res.last       = 1'b1;
				res.body_done  = 1'b1;
				res.length_met = met_q;
				if (out_free) begin
					push     = 1'b1;
					clr_body = 1'b1;
				end
			end
			default: begin
			end
		endcase
		bctl.load = accept && !started_q;
		bctl.dec  = push && res.byte_valid && mode.limit_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			held_q     <= '0;
			pending_q  <= 1'b0;
			nonempty_q <= 1'b0;
			overflow_q <= 1'b0;
			started_q  <= 1'b0;
			met_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				started_q <= 1'b1;
				if (!end_of_body) begin
					if (is_lf) begin
						pending_q <= 1'b0;
						if (held_q >= HeldW'(MAX_HELD_LINES)) begin
							overflow_q <= 1'b1;
						end else begin
							held_q <= held_q + HeldW'(1);
						end
					end else if (is_ws) begin
						pending_q <= 1'b1;
					end else if (is_content) begin
						// A truncated byte still makes the body nonempty.
						nonempty_q <= 1'b1;
					end
				end
			end
			if (dec_held) begin
				held_q <= held_q - HeldW'(1);
			end
			if (clr_content) begin
				held_q    <= '0;
				pending_q <= 1'b0;
			end
			if (set_met) begin
				met_q <= met_val;
			end
			if (clr_body) begin
				held_q     <= '0;
				pending_q  <= 1'b0;
				nonempty_q <= 1'b0;
				overflow_q <= 1'b0;
				started_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_content) begin
			byte_q <= body_byte;
		end
	end

`include "assert_macros.svh"

	`DBC_NEVER(a_no_dec_on_empty, clk, arst_n, bctl.dec && bsts.zero, "budget decremented at zero")
	`DBC_NEVER(a_load_dec_excl, clk, arst_n, bctl.load && bctl.dec, "budget load and decrement")
	`DBC_ASSERT(a_held_bound, clk, arst_n, held_q <= HeldW'(MAX_HELD_LINES), "held lines over bound")
	`DBC_ASSERT(a_push_free, clk, arst_n, push |-> out_free, "result pushed into full output")

endmodule

// ===== sv/dkim_body_canonicalizer_core.sv =====
// Mail body canonicalizer (simple or relaxed) with output truncation and length check.
// A CR, LF or relaxed-mode whitespace byte produces no transfer. A content byte produces up
// to 2 * held lines + 2 results and an end-of-body item 1 or 2; a content byte that arrives
// with the length budget already spent produces no result. The sequencer emits one result
// per cycle into a single output register while that register is free, and stalls while
// the master side holds a result there. The input is not ready while the sequencer works
// on an item. Configuration writes are accepted in every cycle.
module dkim_body_canonicalizer_core #(
	parameter int unsigned MAX_HELD_LINES = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] body_byte
	input  logic        s_tlast,   // end_of_body
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [3:0]  m_tuser,   // [0] byte_valid, [1] body_done, [2] length_met,
	                               // [3] line_overflow
	output logic        m_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import dbc_pkg::*;

	mode_t       mode_q;
	logic [31:0] length_limit_q;

	budget_ctl_t bctl;
	budget_sts_t bsts;
	result_t     res;
	logic        push;
	logic        out_free;

	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic [3:0]  m_tuser_q;
	logic        m_tlast_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= '0;
			length_limit_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RELAXED_MODE: mode_q.relaxed  <= cfg_data[0];
				REG_LIMIT_ENABLE: mode_q.limit_en <= cfg_data[0];
				REG_LENGTH_LIMIT: length_limit_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dbc_budget u_budget (
		.clk          (clk),
		.arst_n       (arst_n),
		.length_limit (length_limit_q),
		.ctl          (bctl),
		.sts          (bsts)
	);

	dbc_seq #(
		.MAX_HELD_LINES (MAX_HELD_LINES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.body_byte   (s_tdata),
		.end_of_body (s_tlast),
		.mode        (mode_q),
		.bsts        (bsts),
		.bctl        (bctl),
		.out_free    (out_free),
		.push        (push),
		.res         (res)
	);

	// The output register frees up in the same cycle its transfer completes.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_tdata_q <= res.out_byte;
			m_tuser_q <= {res.line_overflow, res.length_met, res.body_done, res.byte_valid};
			m_tlast_q <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the DKIM body canonicalizer core.
`timescale 1ns / 100ps

class canon_checker;
	int unsigned held_max;
	int unsigned errors;
	int unsigned results_seen;

	bit relaxed;
	bit limit_en;
	bit [31:0] length_limit;

	bit pending_space;
	int unsigned held_lines;
	bit body_nonempty;
	bit [31:0] bytes_left;
	bit overflow;
	bit body_started;

	dbc_pkg::result_t item_results[$];
	dbc_pkg::result_t canon_due[$];

	function new(int unsigned held_limit);
		held_max = held_limit;
	endfunction

	function void write_reg(logic [dbc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		case (idx)
			dbc_pkg::REG_RELAXED_MODE: relaxed = value[0];
			dbc_pkg::REG_LIMIT_ENABLE: limit_en = value[0];
			dbc_pkg::REG_LENGTH_LIMIT: length_limit = value;
			default: ;
		endcase
	endfunction

	// Every canonical byte marks the body nonempty, even when truncated.
	function void push_canon_byte(logic [7:0] b, logic done);
		dbc_pkg::result_t r;
		body_nonempty = 1'b1;
		if (limit_en) begin
			if (bytes_left == 0)
				return;
			bytes_left--;
		end
		r = '0;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		r.body_done = done;
		r.line_overflow = overflow;
		item_results.push_back(r);
	endfunction

	function void take_raw_item(logic [7:0] b, logic eob);
		logic met;
		dbc_pkg::result_t r;
		item_results.delete();
		if (!body_started) begin
			body_started = 1'b1;
			bytes_left = length_limit;
		end
		if (eob) begin
			if (body_nonempty || !relaxed) begin
				push_canon_byte(dbc_pkg::CHAR_CR, 1'b1);
				push_canon_byte(dbc_pkg::CHAR_LF, 1'b1);
			end
			met = !(limit_en && bytes_left != 0);
			if (item_results.size() == 0) begin
				r = '0;
				r.body_done = 1'b1;
				r.line_overflow = overflow;
				item_results.push_back(r);
			end
			foreach (item_results[i])
				item_results[i].length_met = met;
			pending_space = 1'b0;
			held_lines = 0;
			body_nonempty = 1'b0;
			overflow = 1'b0;
			body_started = 1'b0;
		end else if (b == dbc_pkg::CHAR_LF) begin
			pending_space = 1'b0;
			if (held_lines >= held_max)
				overflow = 1'b1;
			else
				held_lines++;
		end else if (relaxed && (b == dbc_pkg::CHAR_SPACE || b == dbc_pkg::CHAR_TAB)) begin
			pending_space = 1'b1;
		end else if (b != dbc_pkg::CHAR_CR) begin
			while (held_lines != 0) begin
				push_canon_byte(dbc_pkg::CHAR_CR, 1'b0);
				push_canon_byte(dbc_pkg::CHAR_LF, 1'b0);
				held_lines--;
			end
			if (pending_space) begin
				push_canon_byte(dbc_pkg::CHAR_SPACE, 1'b0);
				pending_space = 1'b0;
			end
			push_canon_byte(b, 1'b0);
		end
		if (item_results.size() != 0)
			item_results[item_results.size() - 1].last = 1'b1;
		foreach (item_results[i])
			canon_due.push_back(item_results[i]);
	endfunction

	task report_mismatch(string what);
		if (errors < 40)
			$display("MISMATCH: %s", what);
		errors++;
	endtask

	task check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	task check_canon_result(dbc_pkg::result_t got);
		dbc_pkg::result_t want;
		if (canon_due.size() == 0) begin
			report_mismatch($sformatf("result %0d with byte %02h arrived unexpectedly",
				results_seen, got.out_byte));
		end else begin
			want = canon_due.pop_front();
			check_field("out_byte", got.out_byte, want.out_byte);
			check_field("byte_valid", got.byte_valid, want.byte_valid);
			check_field("last", got.last, want.last);
			check_field("body_done", got.body_done, want.body_done);
			check_field("length_met", got.length_met, want.length_met);
			check_field("line_overflow", got.line_overflow, want.line_overflow);
		end
		results_seen++;
	endtask

	task check_leftovers();
		if (canon_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", canon_due.size()));
	endtask
endclass

module tb;
	localparam int unsigned HELD_MAX = 30;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] b;
		logic       eob;
	} raw_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [dbc_pkg::CFG_IDX_W-1:0] cfg_index = dbc_pkg::REG_RELAXED_MODE;
	logic [31:0] cfg_data = 32'h0;

	canon_checker checker_h;
	raw_item_t raw_q[$];
	raw_item_t next_raw;
	dbc_pkg::result_t seen;
	int unsigned queued_count = 0;
	int unsigned accepted_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned rx_cycle = 0;
	int unsigned rx_mode = 0;
	int unsigned hold_cnt = 0;
	int unsigned idle_cycles = 0;
	bit hold_request = 1'b0;

	dkim_body_canonicalizer_core #(
		.MAX_HELD_LINES(HELD_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Sender: bursts of random length separated by random gaps.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && !(s_tvalid && !s_tready)) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (raw_q.size() != 0) begin
					next_raw = raw_q.pop_front();
					s_tdata <= next_raw.b;
					s_tlast <= next_raw.eob;
					s_tvalid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a stall pattern that is redrawn at random periodically, plus one long hold-off.
	initial begin
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 48 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_cnt = HOLD_OFF_CYCLES;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (rx_cycle % 4 == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				checker_h.take_raw_item(s_tdata, s_tlast);
				accepted_count++;
			end
			if (m_tvalid && m_tready) begin
				seen.out_byte = m_tdata;
				seen.byte_valid = m_tuser[0];
				seen.last = m_tlast;
				seen.body_done = m_tuser[1];
				seen.length_met = m_tuser[2];
				seen.line_overflow = m_tuser[3];
				checker_h.check_canon_result(seen);
			end
		end
	end

	// Watchdog on cycles without any transfer.
	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic add_item(input logic [7:0] b, input logic eob);
		raw_q.push_back('{b: b, eob: eob});
		queued_count++;
	endtask

	task automatic cfg_write(input logic [dbc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		checker_h.write_reg(idx, value);
	endtask

	task automatic set_mode(input bit relaxed, input bit limit_en, input logic [31:0] limit);
		cfg_write(dbc_pkg::REG_RELAXED_MODE, {31'd0, relaxed});
		cfg_write(dbc_pkg::REG_LIMIT_ENABLE, {31'd0, limit_en});
		cfg_write(dbc_pkg::REG_LENGTH_LIMIT, limit);
	endtask

	// Waits until every item is taken and every result is in, then lets the core settle.
	task automatic wait_drained();
		while (accepted_count != queued_count || checker_h.canon_due.size() != 0 ||
				hold_cnt != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One text line: words separated by space/tab runs, usually closed by CRLF.
	task automatic gen_line();
		int unsigned sel;
		repeat ($urandom_range(1, 4)) begin
			repeat ($urandom_range(1, 5))
				add_item(8'($urandom_range(33, 126)), 1'b0);
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 3))
					add_item($urandom_range(0, 1) ? dbc_pkg::CHAR_SPACE : dbc_pkg::CHAR_TAB,
						1'b0);
		end
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			add_item(dbc_pkg::CHAR_CR, 1'b0);
			add_item(dbc_pkg::CHAR_LF, 1'b0);
		end else if (sel < 9) begin
			add_item(dbc_pkg::CHAR_LF, 1'b0);
		end
	endtask

	task automatic gen_random(input int unsigned target);
		int unsigned start_count;
		int unsigned kind;
		start_count = queued_count;
		while (queued_count - start_count < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				gen_line();
			end else if (kind < 70) begin
				repeat ($urandom_range(1, 3)) begin
					add_item(dbc_pkg::CHAR_CR, 1'b0);
					add_item(dbc_pkg::CHAR_LF, 1'b0);
				end
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 5))
					add_item(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				add_item(8'($urandom_range(0, 255)), 1'b1);
			end
		end
		add_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		checker_h = new(HELD_MAX);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Simple mode: empty body, byte extremes, whitespace kept as is.
		set_mode(1'b0, 1'b0, 32'd0);
		add_item(8'h00, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(dbc_pkg::CHAR_CR, 1'b0);
		add_item(dbc_pkg::CHAR_LF, 1'b0);
		add_item(dbc_pkg::CHAR_SPACE, 1'b0);
		add_item(dbc_pkg::CHAR_TAB, 1'b0);
		add_item(8'hFF, 1'b1);
		wait_drained();

		// Relaxed mode: empty body, lone tab, CR inside a space run, trailing space.
		set_mode(1'b1, 1'b0, 32'd0);
		add_item(8'h00, 1'b1);
		add_item("x", 1'b0);
		add_item(dbc_pkg::CHAR_TAB, 1'b0);
		add_item("y", 1'b0);
		add_item(dbc_pkg::CHAR_SPACE, 1'b0);
		add_item(dbc_pkg::CHAR_CR, 1'b0);
		add_item("z", 1'b0);
		add_item(dbc_pkg::CHAR_SPACE, 1'b0);
		add_item(dbc_pkg::CHAR_LF, 1'b0);
		add_item(dbc_pkg::CHAR_LF, 1'b0);
		add_item("q", 1'b0);
		add_item(8'h00, 1'b1);
		wait_drained();

		// Truncation: the third byte and the final CRLF fall past the limit.
		set_mode(1'b0, 1'b1, 32'd2);
		add_item("a", 1'b0);
		add_item("b", 1'b0);
		add_item("c", 1'b0);
		add_item(8'h00, 1'b1);
		wait_drained();

		set_mode(1'b0, 1'b0, 32'd0);
		gen_random(6);
		wait_drained();

		// The receiver holds off while the sender keeps offering.
		set_mode(1'b1, 1'b0, 32'd0);
		hold_request = 1'b1;
		gen_random(6);
		wait_drained();

		set_mode(1'b1, 1'b1, 32'($urandom_range(0, 60)));
		gen_random(6);
		wait_drained();

		set_mode(1'b0, 1'b1, 32'd0);
		gen_random(4);
		wait_drained();

		set_mode(1'b1, 1'b1, 32'hFFFF_FFFF);
		gen_random(6);
		wait_drained();

		// Enough blank lines to saturate the held-line counter.
		set_mode(1'b0, 1'b0, 32'd0);
		repeat (HELD_MAX + 3)
			add_item(dbc_pkg::CHAR_LF, 1'b0);
		add_item("k", 1'b0);
		gen_random(2);
		wait_drained();

		set_mode(1'b0, 1'b1, 32'($urandom_range(5, 40)));
		gen_random(6);
		wait_drained();

		checker_h.check_leftovers();
		if (checker_h.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
